// ===== rtl/fevad_pkg.sv =====
// shared constants, register codes and threshold table for the frame energy vad
package fevad_pkg;

  // default values for the top level parameters
  localparam int MAX_FRAME_DEF       = 1024;
  localparam int HANGOVER_FRAMES_DEF = 30;

  // field widths
  localparam int SAMPLE_W    = 16;
  localparam int SQ_W        = 31;   // a square of a 16-bit sample never exceeds 2^30
  localparam int FRAME_LEN_W = 11;
  localparam int VOL_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int OUT_TDATA_W = 8;

  // volume used outside custom mode
  localparam logic [VOL_W-1:0] FIXED_VOLUME = 7'd35;

  // threshold table: entry i stands for k = i + 30, value is energy in Q8
  localparam int THR_W       = 44;
  localparam int THR_ENTRIES = 64;
  localparam int THR_REF_IDX = 50;   // k = 80, threshold 2^38
  localparam logic [63:0] STEP_UP_Q16   = 64'd86393;
  localparam logic [63:0] STEP_DOWN_Q16 = 64'd49714;
  localparam logic [63:0] HALF_Q16      = 64'd32768;

  typedef logic [THR_W-1:0] thr_rom_t [THR_ENTRIES];

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LENGTH = 2'd0,
    REG_VAD_VOLUME   = 2'd1,
    REG_CUSTOM_MODE  = 2'd2
  } cfg_reg_t;

  // builds the table by stepping 10^(+-0.12) in Q16 away from k = 80
  function automatic thr_rom_t build_thr_rom();
    thr_rom_t    rom;
    logic [63:0] acc;
    rom[THR_REF_IDX] = THR_W'(64'd1 << 38);
    acc = 64'd1 << 38;
    for (int i = THR_REF_IDX + 1; i < THR_ENTRIES; i++) begin
      acc    = (acc * STEP_UP_Q16 + HALF_Q16) >> 16;
      rom[i] = acc[THR_W-1:0];
    end
    acc = 64'd1 << 38;
    for (int i = THR_REF_IDX - 1; i >= 0; i--) begin
      acc    = (acc * STEP_DOWN_Q16 + HALF_Q16) >> 16;
      rom[i] = acc[THR_W-1:0];
    end
    return rom;
  endfunction

  localparam thr_rom_t THR_ROM = build_thr_rom();

endpackage

// ===== rtl/frame_energy_vad_hangover_unit.sv =====
// top level of the frame energy voice activity detector with hangover
//
// Signed 16-bit samples stream in on in_*; one sample is taken every clock cycle as
// long as the result side keeps up. Each sample is squared and added to a frame
// sum that starts at 1; at the last sample of a frame (frame_length samples,
// clamped to 1..MAX_FRAME) the sum is compared against a table threshold scaled
// by the frame length, the hangover counter is updated and one result goes out
// on out_*. A closing sample passes the input register and then the squaring
// register, and the accumulator then loads its result into the result register.
// The only stall comes from the result register: a frame-closing sample waits
// there while an earlier result is still untaken, which backs up the two stages
// in front of it. Configuration writes are always taken; a write passes the
// configuration registers and then the registered frame length and threshold,
// and applies to each sample as the accumulator takes it.
module frame_energy_vad_hangover_unit import fevad_pkg::*; #(
  parameter int MAX_FRAME       = MAX_FRAME_DEF,
  parameter int HANGOVER_FRAMES = HANGOVER_FRAMES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input samples
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [SAMPLE_W-1:0]    in_tdata,    // [15:0] sample
  // per-frame results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [0] speech, [1] loud_frame, [7:2] zero
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LEN_W  = $clog2(MAX_FRAME + 1);
  localparam int PROD_W = LEN_W + THR_W;

  logic [LEN_W-1:0]  frame_len;
  logic [PROD_W-1:0] thr_prod;
  logic              sq_valid, sq_ready;
  logic [SQ_W-1:0]   sq_data;

  // configuration and threshold
  fevad_cfg #(
    .MAX_FRAME (MAX_FRAME)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .frame_len (frame_len),
    .thr_prod  (thr_prod)
  );

  // sample input and squaring
  fevad_sq u_sq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .sq_valid  (sq_valid),
    .sq_ready  (sq_ready),
    .sq_data   (sq_data)
  );

  // accumulation, decision and result
  fevad_acc #(
    .MAX_FRAME       (MAX_FRAME),
    .HANGOVER_FRAMES (HANGOVER_FRAMES)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .sq_valid   (sq_valid),
    .sq_ready   (sq_ready),
    .sq_data    (sq_data),
    .frame_len  (frame_len),
    .thr_prod   (thr_prod),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/fevad_cfg.sv =====
// configuration registers, effective frame length and scaled threshold
module fevad_cfg import fevad_pkg::*; #(
  parameter int MAX_FRAME = MAX_FRAME_DEF,
  localparam int LEN_W  = $clog2(MAX_FRAME + 1),
  localparam int PROD_W = LEN_W + THR_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [LEN_W-1:0]      frame_len,
  output logic [PROD_W-1:0]     thr_prod
);

  logic [FRAME_LEN_W-1:0] frame_length_r, frame_length_nxt;
  logic [VOL_W-1:0]       vad_volume_r, vad_volume_nxt;
  logic                   custom_mode_r, custom_mode_nxt;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [VOL_W-1:0]       vol_sel;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes, unknown indexes ignored
  always_comb begin
    frame_length_nxt = frame_length_r;
    vad_volume_nxt   = vad_volume_r;
    custom_mode_nxt  = custom_mode_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_LENGTH: frame_length_nxt = cfg_data[FRAME_LEN_W-1:0];
        REG_VAD_VOLUME:   vad_volume_nxt   = cfg_data[VOL_W-1:0];
        REG_CUSTOM_MODE:  custom_mode_nxt  = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= FRAME_LEN_W'(160);
      vad_volume_r   <= VOL_W'(30);
      custom_mode_r  <= 1'b0;
    end else begin
      frame_length_r <= frame_length_nxt;
      vad_volume_r   <= vad_volume_nxt;
      custom_mode_r  <= custom_mode_nxt;
    end
  end

  // frame length clamped to 1..MAX_FRAME
  always_comb begin
    if (frame_length_r == '0) begin
      len_nxt = LEN_W'(1);
    end else if (32'(frame_length_r) > 32'(MAX_FRAME)) begin
      len_nxt = LEN_W'(MAX_FRAME);
    end else begin
      len_nxt = LEN_W'(frame_length_r);
    end
  end

  // k - 30 is vol / 2, which spans the whole table
  assign vol_sel  = custom_mode_r ? vad_volume_r : FIXED_VOLUME;
  assign prod_nxt = PROD_W'(len_nxt) * PROD_W'(THR_ROM[vol_sel[VOL_W-1:1]]);

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    prod_r <= prod_nxt;
  end

  assign frame_len = len_r;
  assign thr_prod  = prod_r;

endmodule

// ===== rtl/fevad_sq.sv =====
// input register and squaring stage
module fevad_sq import fevad_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [SAMPLE_W-1:0] in_tdata,
  output logic                sq_valid,
  input  logic                sq_ready,
  output logic [SQ_W-1:0]     sq_data
);

  logic                       s1_v_r, s1_v_nxt;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       s2_v_r, s2_v_nxt;
  logic [SQ_W-1:0]            sq_r;
  logic                       s1_ready, s2_ready;
  logic signed [2*SAMPLE_W-1:0] sq_full;

  // a stage takes a new item when it is empty or its item moves on
  assign s2_ready  = !s2_v_r || sq_ready;
  assign s1_ready  = !s1_v_r || s2_ready;
  assign in_tready = s1_ready;

  assign s1_v_nxt = s1_ready ? in_tvalid : s1_v_r;
  assign s2_v_nxt = s2_ready ? s1_v_r : s2_v_r;

  assign sq_full = sample_r * sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && s1_ready) begin
      sample_r <= $signed(in_tdata);
    end
    if (s1_v_r && s2_ready) begin
      sq_r <= sq_full[SQ_W-1:0];
    end
  end

  assign sq_valid = s2_v_r;
  assign sq_data  = sq_r;

endmodule

// ===== rtl/fevad_acc.sv =====
// energy accumulator, frame decision, hangover counter and result register
module fevad_acc import fevad_pkg::*; #(
  parameter int MAX_FRAME       = MAX_FRAME_DEF,
  parameter int HANGOVER_FRAMES = HANGOVER_FRAMES_DEF,
  localparam int LEN_W  = $clog2(MAX_FRAME + 1),
  localparam int PROD_W = LEN_W + THR_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   sq_valid,
  output logic                   sq_ready,
  input  logic [SQ_W-1:0]        sq_data,
  input  logic [LEN_W-1:0]       frame_len,
  input  logic [PROD_W-1:0]      thr_prod,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int SUM_W  = $clog2(MAX_FRAME) + 31;
  localparam int HANG_W = $clog2(HANGOVER_FRAMES + 1);
  localparam int CMP_W  = (SUM_W + 8 > PROD_W) ? SUM_W + 8 : PROD_W;
  localparam logic [HANG_W-1:0] HANG_LIMIT = HANG_W'(HANGOVER_FRAMES);

  logic [SUM_W-1:0]  sum_r, sum_nxt, sum_inc;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [HANG_W-1:0] quiet_r, quiet_nxt, quiet_upd;
  logic              out_v_r, out_v_nxt;
  logic              speech_r, loud_r;
  logic              frame_end, loud, fire, out_free;

  // running sums including this sample
  assign sum_inc   = sum_r + SUM_W'(sq_data);
  assign cnt_inc   = cnt_r + LEN_W'(1);
  assign frame_end = cnt_inc >= frame_len;
  assign loud      = CMP_W'({sum_inc, 8'h00}) > CMP_W'(thr_prod);

  // a sample that closes a frame waits for room in the result register
  assign out_free = !out_v_r || out_tready;
  assign sq_ready = !frame_end || out_free;
  assign fire     = sq_valid && sq_ready;

  // hangover count clears on loud frames and saturates at the limit
  always_comb begin
    if (loud) begin
      quiet_upd = '0;
    end else if (quiet_r < HANG_LIMIT) begin
      quiet_upd = quiet_r + HANG_W'(1);
    end else begin
      quiet_upd = quiet_r;
    end
  end

  // accumulator and frame bookkeeping
  always_comb begin
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    quiet_nxt = quiet_r;
    if (fire) begin
      if (frame_end) begin
        sum_nxt   = SUM_W'(1);
        cnt_nxt   = '0;
        quiet_nxt = quiet_upd;
      end else begin
        sum_nxt = sum_inc;
        cnt_nxt = cnt_inc;
      end
    end
  end

  // result register valid
  always_comb begin
    if (fire && frame_end) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= SUM_W'(1);
      cnt_r   <= '0;
      quiet_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      sum_r   <= sum_nxt;
      cnt_r   <= cnt_nxt;
      quiet_r <= quiet_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire && frame_end) begin
      speech_r <= quiet_upd < HANG_LIMIT;
      loud_r   <= loud;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, loud_r, speech_r};

  // hangover count never passes its limit
  a_quiet_bound: assert property (@(posedge clk) disable iff (!rst_n)
    quiet_r <= HANG_LIMIT)
    else $error("hangover count above limit");

  // a loud frame is always reported as speech
  a_loud_is_speech: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (!loud_r || speech_r))
    else $error("loud frame reported as silence");

  // closing a frame restarts the sum and the count
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && frame_end) |=> (sum_r == SUM_W'(1) && cnt_r == '0))
    else $error("frame state not restarted");

  // a new result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |-> !(fire && frame_end))
    else $error("pending result overwritten");

  // the sample count stays inside the largest frame
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) < 32'(MAX_FRAME))
    else $error("sample count out of range");

endmodule
